// ----- rtl/core/bpcm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpcm_pkg
// Shared types, codes and defaults of the permission-checked guest memory.
// ----------------------------------------------------------------------------
package bpcm_pkg;

  // default geometry
  localparam int MEM_BYTES_DEF   = 65536;
  localparam int BLOCK_BYTES_DEF = 64;
  localparam int MAX_LEN_DEF     = 8;
  localparam int FETCH_BYTES     = 4;

  // stream widths (fields packed low to high, padded to whole bytes)
  localparam int IN_W  = 120;
  localparam int OUT_W = 120;

  // permission nibble bits
  localparam logic [3:0] ACC_RD   = 4'b0001;
  localparam logic [3:0] ACC_WR   = 4'b0010;
  localparam logic [3:0] ACC_EX   = 4'b0100;
  localparam logic [3:0] ACC_INIT = 4'b1000;

  typedef enum logic [2:0] {
    MODE_READ      = 3'd0,
    MODE_WRITE     = 3'd1,
    MODE_FETCH     = 3'd2,
    MODE_SETPERM   = 3'd3,
    MODE_DIRTY_RD  = 3'd4,
    MODE_DIRTY_CLR = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    FAULT_NONE      = 3'd0,
    FAULT_OOB_READ  = 3'd1,
    FAULT_OOB_WRITE = 3'd2,
    FAULT_OOB_EXEC  = 3'd3,
    FAULT_MISALIGN  = 3'd4,
    FAULT_READ      = 3'd5,
    FAULT_WRITE     = 3'd6,
    FAULT_EXEC      = 3'd7
  } fault_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CK,
    S_WRITE,
    S_LOG_RD,
    S_LOG_CK,
    S_LIST_RD,
    S_LIST_CK,
    S_CLEAR,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic check;
    logic scan_rd;
    logic scan_ck;
    logic wr_byte;
    logic log_rd;
    logic log_ck;
    logic list_rd;
    logic list_ck;
    logic sweep_mem;
    logic sweep_blk;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  bounds_fail;
    logic  zero_len;
    logic  byte_fail;
    logic  last_byte;
    logic  last_block;
    logic  sweep_mem_last;
    logic  sweep_blk_last;
    logic  out_free;
  } status_t;

endpackage

// ----- rtl/core/bpcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpcm_ctrl
// Sequencer: init sweep, then check, scan, write, dirty logging, list, clear.
// ----------------------------------------------------------------------------
module bpcm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpcm_pkg::status_t st,
  output bpcm_pkg::cmd_t    cmd
);

  bpcm_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpcm_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpcm_pkg::S_INIT: begin
        if (st.sweep_mem_last) state_next = bpcm_pkg::S_IDLE;
      end
      bpcm_pkg::S_IDLE: begin
        if (in_valid) state_next = bpcm_pkg::S_CHECK;
      end
      bpcm_pkg::S_CHECK: begin
        case (st.mode) inside
          bpcm_pkg::MODE_READ, bpcm_pkg::MODE_WRITE, bpcm_pkg::MODE_FETCH: begin
            if (st.bounds_fail || st.zero_len) state_next = bpcm_pkg::S_DONE;
            else state_next = bpcm_pkg::S_SCAN_RD;
          end
          bpcm_pkg::MODE_SETPERM: begin
            if (st.bounds_fail || st.zero_len) state_next = bpcm_pkg::S_DONE;
            else state_next = bpcm_pkg::S_WRITE;
          end
          bpcm_pkg::MODE_DIRTY_RD:  state_next = bpcm_pkg::S_LIST_RD;
          bpcm_pkg::MODE_DIRTY_CLR: state_next = bpcm_pkg::S_CLEAR;
          default:                  state_next = bpcm_pkg::S_DONE;
        endcase
      end
      bpcm_pkg::S_SCAN_RD: state_next = bpcm_pkg::S_SCAN_CK;
      bpcm_pkg::S_SCAN_CK: begin
        if (st.byte_fail) state_next = bpcm_pkg::S_DONE;
        else if (!st.last_byte) state_next = bpcm_pkg::S_SCAN_RD;
        else if (st.mode == bpcm_pkg::MODE_WRITE) state_next = bpcm_pkg::S_WRITE;
        else state_next = bpcm_pkg::S_DONE;
      end
      bpcm_pkg::S_WRITE: begin
        if (st.last_byte) state_next = bpcm_pkg::S_LOG_RD;
      end
      bpcm_pkg::S_LOG_RD: state_next = bpcm_pkg::S_LOG_CK;
      bpcm_pkg::S_LOG_CK: begin
        if (st.last_block) state_next = bpcm_pkg::S_DONE;
        else state_next = bpcm_pkg::S_LOG_RD;
      end
      bpcm_pkg::S_LIST_RD: state_next = bpcm_pkg::S_LIST_CK;
      bpcm_pkg::S_LIST_CK: state_next = bpcm_pkg::S_DONE;
      bpcm_pkg::S_CLEAR: begin
        if (st.sweep_blk_last) state_next = bpcm_pkg::S_DONE;
      end
      bpcm_pkg::S_DONE: begin
        if (st.out_free) state_next = bpcm_pkg::S_IDLE;
      end
      default: state_next = bpcm_pkg::S_INIT;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      bpcm_pkg::S_INIT: cmd.sweep_mem = 1'b1;
      bpcm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bpcm_pkg::S_CHECK:   cmd.check   = 1'b1;
      bpcm_pkg::S_SCAN_RD: cmd.scan_rd = 1'b1;
      bpcm_pkg::S_SCAN_CK: cmd.scan_ck = 1'b1;
      bpcm_pkg::S_WRITE:   cmd.wr_byte = 1'b1;
      bpcm_pkg::S_LOG_RD:  cmd.log_rd  = 1'b1;
      bpcm_pkg::S_LOG_CK:  cmd.log_ck  = 1'b1;
      bpcm_pkg::S_LIST_RD: cmd.list_rd = 1'b1;
      bpcm_pkg::S_LIST_CK: cmd.list_ck = 1'b1;
      bpcm_pkg::S_CLEAR:   cmd.sweep_blk = 1'b1;
      bpcm_pkg::S_DONE:    cmd.finish  = st.out_free;
      default: cmd = '0;
    endcase
  end

  // a request is only taken when no other work is under way
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == bpcm_pkg::S_IDLE && in_valid))
    else $error("load outside idle");
  // handing over the result returns the sequencer to idle
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == bpcm_pkg::S_IDLE))
    else $error("finish did not return to idle");

endmodule

// ----- rtl/core/bpcm_dpath.sv -----
// ----------------------------------------------------------------------------
// bpcm_dpath
// Data, permission, dirty flag and dirty list memories plus request registers.
// ----------------------------------------------------------------------------
module bpcm_dpath #(
  parameter int MEM_BYTES   = bpcm_pkg::MEM_BYTES_DEF,
  parameter int BLOCK_BYTES = bpcm_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_LEN     = bpcm_pkg::MAX_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [bpcm_pkg::IN_W-1:0]  in_data,
  input  bpcm_pkg::cmd_t            cmd,
  output bpcm_pkg::status_t         st,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bpcm_pkg::OUT_W-1:0] out_data
);

  localparam int NUM_BLOCKS = (MEM_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int ADDR_W     = $clog2(MEM_BYTES);
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int IDX_W      = $clog2(MAX_LEN);

  // memories
  logic [7:0]       data_mem [MEM_BYTES];
  logic [3:0]       perm_mem [MEM_BYTES];
  logic             flag_mem [NUM_BLOCKS];
  logic [BLK_W-1:0] list_mem [NUM_BLOCKS];

  // request registers
  bpcm_pkg::mode_t mode_q;
  logic [31:0]     addr_q;
  logic [3:0]      n_q;
  logic [63:0]     wdata_q;
  logic [3:0]      pv_q;
  logic [9:0]      di_q;

  // working registers
  logic [IDX_W-1:0] idx;
  logic [ADDR_W-1:0] cnt;
  logic [BLK_W-1:0] blk, blk_last;
  logic [CNT_W-1:0] total;
  logic [7:0]       data_q;
  logic [3:0]       perm_q;
  logic             flag_q;
  logic [BLK_W-1:0] list_q;
  logic [3:0]       pbuf [MAX_LEN];
  bpcm_pkg::fault_t res_fault;
  logic [31:0]      res_fa;
  logic [63:0]      res_rd;
  logic [9:0]       res_db;

  // output register
  bpcm_pkg::fault_t o_fault;
  logic [31:0]      o_fa;
  logic [63:0]      o_rd;
  logic [9:0]       o_db;
  logic [10:0]      o_cnt;

  // decoded input
  logic [3:0]  len_in, n_in;
  bpcm_pkg::mode_t mode_in;

  // derived values
  logic [32:0]       end_sum;
  logic [ADDR_W-1:0] byte_addr, first_addr, last_addr;
  logic [3:0]        need;
  logic              misaligned;
  logic              byte_fail;

  assign mode_in = bpcm_pkg::mode_t'(in_data[2:0]);
  assign len_in  = in_data[38:35];
  always_comb begin
    if (mode_in == bpcm_pkg::MODE_FETCH) n_in = 4'(bpcm_pkg::FETCH_BYTES);
    else if (len_in > 4'(MAX_LEN)) n_in = 4'(MAX_LEN);
    else n_in = len_in;
  end

  assign end_sum    = {1'b0, addr_q} + 33'(n_q);
  assign first_addr = addr_q[ADDR_W-1:0];
  assign byte_addr  = first_addr + ADDR_W'(idx);
  assign last_addr  = first_addr + ADDR_W'(n_q) - ADDR_W'(1);
  assign misaligned = (addr_q & 32'(bpcm_pkg::FETCH_BYTES - 1)) != 32'd0;

  // permission bit needed by the access
  always_comb begin
    case (mode_q)
      bpcm_pkg::MODE_READ:  need = bpcm_pkg::ACC_RD;
      bpcm_pkg::MODE_WRITE: need = bpcm_pkg::ACC_WR;
      bpcm_pkg::MODE_FETCH: need = bpcm_pkg::ACC_EX;
      default:              need = 4'd0;
    endcase
  end
  assign byte_fail = (perm_q & need) != need;

  // status
  assign st.mode           = mode_q;
  assign st.bounds_fail    = end_sum > 33'(MEM_BYTES);
  assign st.zero_len       = (n_q == 4'd0);
  assign st.byte_fail      = byte_fail;
  assign st.last_byte      = (4'(idx) == n_q - 4'd1);
  assign st.last_block     = (blk == blk_last);
  assign st.sweep_mem_last = (cnt == ADDR_W'(MEM_BYTES - 1));
  assign st.sweep_blk_last = (cnt == ADDR_W'(NUM_BLOCKS - 1));
  assign st.out_free       = !out_valid || out_ready;

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode_in;
      addr_q  <= in_data[34:3];
      n_q     <= n_in;
      wdata_q <= in_data[102:39];
      pv_q    <= in_data[106:103];
      di_q    <= in_data[116:107];
    end
  end

  // byte index
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.check) begin
      idx <= '0;
    end else if (cmd.scan_ck || cmd.wr_byte) begin
      idx <= st.last_byte ? '0 : idx + IDX_W'(1);
    end
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.sweep_mem) begin
      cnt <= st.sweep_mem_last ? '0 : cnt + ADDR_W'(1);
    end else if (cmd.sweep_blk) begin
      cnt <= st.sweep_blk_last ? '0 : cnt + ADDR_W'(1);
    end
  end

  // data and permission memories
  always_ff @(posedge clk) begin
    if (cmd.sweep_mem) begin
      data_mem[cnt] <= 8'd0;
      perm_mem[cnt] <= 4'd0;
    end else if (cmd.wr_byte) begin
      if (mode_q == bpcm_pkg::MODE_WRITE) begin
        data_mem[byte_addr] <= wdata_q[8*idx +: 8];
        perm_mem[byte_addr] <= pbuf[idx] | bpcm_pkg::ACC_INIT;
      end else begin
        perm_mem[byte_addr] <= pv_q;
      end
    end
    if (cmd.scan_rd) begin
      data_q <= data_mem[byte_addr];
      perm_q <= perm_mem[byte_addr];
    end
  end

  // permission snapshot for the init-bit update
  always_ff @(posedge clk) begin
    if (cmd.scan_ck) pbuf[idx] <= perm_q;
  end

  // dirty flag memory
  always_ff @(posedge clk) begin
    if (cmd.sweep_mem) begin
      if (32'(cnt) < 32'(NUM_BLOCKS)) flag_mem[BLK_W'(cnt)] <= 1'b0;
    end else if (cmd.sweep_blk) begin
      flag_mem[BLK_W'(cnt)] <= 1'b0;
    end else if (cmd.log_ck && !flag_q) begin
      flag_mem[blk] <= 1'b1;
    end
    if (cmd.log_rd) flag_q <= flag_mem[blk];
  end

  // dirty list memory
  always_ff @(posedge clk) begin
    if (cmd.log_ck && !flag_q && 32'(total) < 32'(NUM_BLOCKS)) begin
      list_mem[BLK_W'(total)] <= blk;
    end
    if (cmd.list_rd) list_q <= list_mem[BLK_W'(di_q)];
  end

  // block range of the access
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      blk      <= BLK_W'(32'(first_addr) / BLOCK_BYTES);
      blk_last <= BLK_W'(32'(last_addr) / BLOCK_BYTES);
    end else if (cmd.log_ck && !st.last_block) begin
      blk <= blk + BLK_W'(1);
    end
  end

  // dirty count
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.sweep_blk && st.sweep_blk_last) begin
      total <= '0;
    end else if (cmd.log_ck && !flag_q && 32'(total) < 32'(NUM_BLOCKS)) begin
      total <= total + CNT_W'(1);
    end
  end

  // working result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_fault <= bpcm_pkg::FAULT_NONE;
      res_fa    <= 32'd0;
      res_rd    <= 64'd0;
      res_db    <= 10'd0;
    end else if (cmd.check && st.bounds_fail) begin
      case (mode_q) inside
        bpcm_pkg::MODE_READ: begin
          res_fa    <= addr_q;
          res_fault <= bpcm_pkg::FAULT_OOB_READ;
        end
        bpcm_pkg::MODE_FETCH: begin
          res_fa    <= addr_q;
          res_fault <= bpcm_pkg::FAULT_OOB_EXEC;
        end
        bpcm_pkg::MODE_WRITE, bpcm_pkg::MODE_SETPERM: begin
          res_fa    <= addr_q;
          res_fault <= bpcm_pkg::FAULT_OOB_WRITE;
        end
        default: ;
      endcase
    end else if (cmd.scan_ck) begin
      if (mode_q == bpcm_pkg::MODE_READ || mode_q == bpcm_pkg::MODE_FETCH) begin
        res_rd[8*idx +: 8] <= data_q;
      end
      if (byte_fail) begin
        res_fa <= addr_q + 32'(idx);
        case (mode_q)
          bpcm_pkg::MODE_READ:  res_fault <= bpcm_pkg::FAULT_READ;
          bpcm_pkg::MODE_WRITE: res_fault <= bpcm_pkg::FAULT_WRITE;
          default:              res_fault <= bpcm_pkg::FAULT_EXEC;
        endcase
      end else if (st.last_byte && mode_q == bpcm_pkg::MODE_FETCH && misaligned) begin
        res_fa    <= addr_q;
        res_fault <= bpcm_pkg::FAULT_MISALIGN;
      end
    end else if (cmd.list_ck) begin
      res_db <= (32'(di_q) < 32'(total)) ? 10'(list_q) : 10'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_fault <= res_fault;
      o_fa    <= res_fa;
      o_rd    <= (res_fault == bpcm_pkg::FAULT_NONE) ? res_rd : 64'd0;
      o_db    <= res_db;
      o_cnt   <= 11'(total);
    end
  end

  assign out_data = {o_cnt, o_db, o_rd, o_fa, o_fault};

  // never more logged blocks than blocks
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= 32'(NUM_BLOCKS))
    else $error("dirty count beyond block count");
  // an access of at most eight bytes spans one or two blocks
  a_block_span: assert property (@(posedge clk) disable iff (rst)
    cmd.log_ck |-> (blk_last == blk || blk_last == blk + BLK_W'(1)))
    else $error("block range too wide");
  // the byte scan stays inside the access
  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_ck || cmd.wr_byte) |-> (4'(idx) < n_q))
    else $error("byte index past access length");

endmodule

// ----- rtl/core/byte_permission_checked_memory_top.sv -----
// ----------------------------------------------------------------------------
// byte_permission_checked_memory_top
// Guest memory with per-byte permissions and dirty-block logging.
// ----------------------------------------------------------------------------
// After reset the block clears its data and permission memories one byte per
// cycle and takes no request until that is done. Each request then runs
// through a sequencer over single-port memories: accept and check, then a read
// and a check step per byte scanned (read, write, fetch), a write step per byte
// written (write, set perms), a read and a check step per block logged (one or
// two blocks), and a hand-over of the result, which waits while the output
// register is full. Reading a dirty entry steps through a list read and a list
// check; clearing dirty tracking sweeps the flag memory, one block per cycle.
// The next request is taken while the previous result waits in the output
// register.
module byte_permission_checked_memory_top #(
  parameter int MEM_BYTES   = bpcm_pkg::MEM_BYTES_DEF,
  parameter int BLOCK_BYTES = bpcm_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_LEN     = bpcm_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // mode[2:0], address[34:3], length[38:35], write_data[102:39],
  // perm_value[106:103], dirty_index[116:107], zero pad
  input  logic [bpcm_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // fault[2:0], fault_address[34:3], read_data[98:35], dirty_block[108:99],
  // dirty_count[119:109]
  output logic [bpcm_pkg::OUT_W-1:0] m_axis_tdata
);

  bpcm_pkg::cmd_t    cmd;
  bpcm_pkg::status_t st;

  // sequencer
  bpcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // memories and registers
  bpcm_dpath #(
    .MEM_BYTES   (MEM_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_LEN     (MAX_LEN)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- tb/bpcm_checker.sv -----
// ----------------------------------------------------------------------------
// bpcm_checker
// Watches both streams of the permission-checked guest memory, predicts each
// result from a private copy of the memory, permissions and dirty log, and
// compares every returned result field by field in order.
// ----------------------------------------------------------------------------
module bpcm_checker
  import bpcm_pkg::*;
#(
  parameter int MEM_BYTES   = MEM_BYTES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int MAX_LEN     = MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,
  output int               error_count,
  output int               pending_count
);

  localparam int NUM_BLOCKS = (MEM_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;

  typedef struct packed {
    logic [10:0] dirty_count;
    logic [9:0]  dirty_block;
    logic [63:0] read_data;
    logic [31:0] fault_address;
    logic [2:0]  fault;
  } mem_result_t;

  logic [7:0]  shadow_data  [MEM_BYTES];
  logic [3:0]  shadow_perm  [MEM_BYTES];
  logic        shadow_flag  [NUM_BLOCKS];
  logic [9:0]  shadow_list  [NUM_BLOCKS];
  int          shadow_total;
  mem_result_t result_queue [$];

  assign pending_count = result_queue.size();

  // Mark touched blocks dirty, ascending, each once
  function automatic void mark_dirty(longint unsigned addr, longint unsigned len);
    longint unsigned b, last;
    if (len == 0) return;
    last = (addr + len - 1) / BLOCK_BYTES;
    for (b = addr / BLOCK_BYTES; b <= last && b < NUM_BLOCKS; b++) begin
      if (!shadow_flag[b]) begin
        shadow_flag[b] = 1'b1;
        if (shadow_total < NUM_BLOCKS) begin
          shadow_list[shadow_total] = b[9:0];
          shadow_total++;
        end
      end
    end
  endfunction

  // Returns index of first byte lacking need, or len
  function automatic int first_denied(longint unsigned addr, int len, logic [3:0] need);
    for (int i = 0; i < len; i++)
      if ((shadow_perm[addr + i] & need) != need) return i;
    return len;
  endfunction

  function automatic mem_result_t predict_access(logic [IN_W-1:0] req);
    mem_result_t     r;
    logic [2:0]      mode;
    longint unsigned addr;
    int              len, k;
    logic [63:0]     wdata;
    logic [3:0]      pv;
    int              di;
    mode  = req[2:0];
    addr  = req[34:3];
    len   = req[38:35];
    wdata = req[102:39];
    pv    = req[106:103];
    di    = req[116:107];
    r = '0;
    if (len > MAX_LEN) len = MAX_LEN;
    case (mode)
      MODE_READ: begin
        if (addr + len > MEM_BYTES) begin
          r.fault = FAULT_OOB_READ; r.fault_address = addr;
        end else begin
          k = first_denied(addr, len, ACC_RD);
          if (k < len) begin
            r.fault = FAULT_READ; r.fault_address = addr + k;
          end else
            for (int i = 0; i < len; i++) r.read_data[8*i +: 8] = shadow_data[addr + i];
        end
      end
      MODE_WRITE: begin
        if (addr + len > MEM_BYTES) begin
          r.fault = FAULT_OOB_WRITE; r.fault_address = addr;
        end else begin
          k = first_denied(addr, len, ACC_WR);
          if (k < len) begin
            r.fault = FAULT_WRITE; r.fault_address = addr + k;
          end else begin
            for (int i = 0; i < len; i++) begin
              shadow_data[addr + i] = wdata[8*i +: 8];
              shadow_perm[addr + i] |= ACC_INIT;
            end
            mark_dirty(addr, len);
          end
        end
      end
      MODE_FETCH: begin
        if (addr + FETCH_BYTES > MEM_BYTES) begin
          r.fault = FAULT_OOB_EXEC; r.fault_address = addr;
        end else begin
          k = first_denied(addr, FETCH_BYTES, ACC_EX);
          if (k < FETCH_BYTES) begin
            r.fault = FAULT_EXEC; r.fault_address = addr + k;
          end else if (addr[1:0] != 2'b00) begin
            r.fault = FAULT_MISALIGN; r.fault_address = addr;
          end else
            for (int i = 0; i < FETCH_BYTES; i++)
              r.read_data[8*i +: 8] = shadow_data[addr + i];
        end
      end
      MODE_SETPERM: begin
        if (addr + len > MEM_BYTES) begin
          r.fault = FAULT_OOB_WRITE; r.fault_address = addr;
        end else begin
          for (int i = 0; i < len; i++) shadow_perm[addr + i] = pv;
          mark_dirty(addr, len);
        end
      end
      MODE_DIRTY_RD: if (di < shadow_total) r.dirty_block = shadow_list[di];
      MODE_DIRTY_CLR: begin
        for (int b = 0; b < NUM_BLOCKS; b++) shadow_flag[b] = 1'b0;
        shadow_total = 0;
      end
      default: ;
    endcase
    r.dirty_count = shadow_total;
    return r;
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    mem_result_t want, got;
    if (rst) begin
      for (int i = 0; i < MEM_BYTES; i++) begin
        shadow_data[i] = '0; shadow_perm[i] = '0;
      end
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        shadow_flag[b] = 1'b0; shadow_list[b] = '0;
      end
      shadow_total = 0;
      error_count  = 0;
      result_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (result_queue.size() == 0) begin
          $display("%0t: result with none pending: %h", $realtime, got);
          error_count++;
        end else begin
          want = result_queue.pop_front();
          if (got.fault !== want.fault || got.fault_address !== want.fault_address ||
              got.read_data !== want.read_data || got.dirty_block !== want.dirty_block ||
              got.dirty_count !== want.dirty_count) begin
            $display("%0t: mismatch expected f=%0d fa=%h rd=%h db=%0d dc=%0d", $realtime,
                     want.fault, want.fault_address, want.read_data, want.dirty_block,
                     want.dirty_count);
            $display("%0t:          actual   f=%0d fa=%h rd=%h db=%0d dc=%0d", $realtime,
                     got.fault, got.fault_address, got.read_data, got.dirty_block,
                     got.dirty_count);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        result_queue.push_back(predict_access(s_axis_tdata));
    end
  end

endmodule

// ----- tb/byte_permission_checked_memory_top_tb.sv -----
// ----------------------------------------------------------------------------
// byte_permission_checked_memory_top_tb
// Drives directed and random guest accesses into the checked memory with
// random idling on both streams; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module byte_permission_checked_memory_top_tb;
  import bpcm_pkg::*;

  localparam int MEM_BYTES = MEM_BYTES_DEF;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  int               error_count, pending_count;
  int               send_idle = 0, recv_idle = 0;
  bit               hold_off = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_permission_checked_memory_top i_dut (.*);

  bpcm_checker i_checker (.*);

  // Receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // Pack one request and hand it over, idling at random first; valid is
  // left high after the accept and is lowered by the next idle or drain
  task automatic send_request(logic [2:0] mode, logic [31:0] addr, logic [3:0] len,
                              logic [63:0] wdata, logic [3:0] pv, logic [9:0] di);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    s_axis_tdata  <= {3'b0, di, pv, wdata, len, addr, mode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Mostly a small hot window so permissions and data interact
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(19))
      0:       return $urandom;
      1:       return MEM_BYTES - $urandom_range(12);
      2:       return $urandom_range(MEM_BYTES - 1);
      default: return $urandom_range(511);
    endcase
  endfunction

  task automatic random_request();
    logic [2:0] mode;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 25)      mode = MODE_WRITE;
    else if (pick < 45) mode = MODE_READ;
    else if (pick < 60) mode = MODE_FETCH;
    else if (pick < 80) mode = MODE_SETPERM;
    else if (pick < 95) mode = MODE_DIRTY_RD;
    else if (pick < 97) mode = MODE_DIRTY_CLR;
    else                mode = 3'($urandom_range(7));
    send_request(mode, pick_addr(), 4'($urandom_range(15)), {$urandom, $urandom},
                 ($urandom_range(3) == 0) ? 4'($urandom) : 4'b0111,
                 ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(20)));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, every mode, special cases
    send_request(MODE_READ, 32'd0, 4'd8, '0, '0, '0);             // no permission
    send_request(MODE_SETPERM, 32'd0, 4'd15, '0, 4'hF, '0);       // length saturates
    send_request(MODE_WRITE, 32'd0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    send_request(MODE_READ, 32'd0, 4'd8, '0, '0, '0);
    send_request(MODE_FETCH, 32'd0, 4'd0, '0, '0, '0);
    send_request(MODE_FETCH, 32'd2, 4'd0, '0, '0, '0);            // misaligned
    send_request(MODE_SETPERM, 32'd60, 4'd8, '0, 4'h2, '0);       // straddles blocks
    send_request(MODE_WRITE, 32'd60, 4'd8, 64'h0123_4567_89AB_CDEF, '0, '0);
    send_request(MODE_READ, 32'd60, 4'd8, '0, '0, '0);            // write-only
    send_request(MODE_FETCH, 32'd64, 4'd0, '0, '0, '0);
    send_request(MODE_WRITE, 32'd100, 4'd0, '0, '0, '0);          // zero length
    send_request(MODE_READ, MEM_BYTES, 4'd0, '0, '0, '0);
    send_request(MODE_READ, MEM_BYTES + 1, 4'd0, '0, '0, '0);
    send_request(MODE_WRITE, MEM_BYTES - 4, 4'd8, '0, '0, '0);
    send_request(MODE_FETCH, 32'hFFFF_FFFF, 4'd0, '0, '0, '0);
    send_request(MODE_SETPERM, 32'hFFFF_FFF8, 4'd8, '0, 4'hF, '0);
    send_request(MODE_SETPERM, MEM_BYTES - 8, 4'd8, '0, 4'hF, '0);
    send_request(MODE_WRITE, MEM_BYTES - 8, 4'd8, 64'hA5A5_5A5A_0F0F_F0F0, '0, '0);
    send_request(MODE_READ, MEM_BYTES - 8, 4'd8, '0, '0, '0);
    send_request(MODE_DIRTY_RD, '0, '0, '0, '0, 10'd0);
    send_request(MODE_DIRTY_RD, '0, '0, '0, '0, 10'd3);
    send_request(MODE_DIRTY_RD, '0, '0, '0, '0, 10'h3FF);
    send_request(3'd6, '0, '0, '0, '0, '0);
    send_request(3'd7, 32'hFFFF_FFFF, 4'hF, '1, 4'hF, '1);
    send_request(MODE_DIRTY_CLR, '0, '0, '0, '0, '0);
    send_request(MODE_DIRTY_RD, '0, '0, '0, '0, 10'd0);
    // three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 23 : (phase == 1) ? 58 : 0;
      recv_idle = (phase == 0) ? 58 : (phase == 1) ? 23 : 0;
      for (int n = 0; n < 460; n++) begin
        if (phase == 0 && n == 200) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (400) @(negedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        if (n == 300) wait_drained();
        random_request();
      end
    end
    wait_drained();
    repeat (2000) @(negedge clk);
    if (error_count == 0 && pending_count == 0)
      $display("byte_permission_checked_memory_top_tb: PASS");
    else
      $display("byte_permission_checked_memory_top_tb: FAIL");
    $finish;
  end

  // Limit: init sweep plus ~1400 slow requests and dirty clears
  initial begin
    #4000000;
    $display("byte_permission_checked_memory_top_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bpcm_pkg.sv
rtl/core/bpcm_ctrl.sv
rtl/core/bpcm_dpath.sv
rtl/core/byte_permission_checked_memory_top.sv
tb/bpcm_checker.sv
tb/byte_permission_checked_memory_top_tb.sv
